[src/lsz_pkg.sv]
// Shared constants, types and helper functions for the zero-crossing edge marker.
`timescale 1ns / 1ps
`default_nettype none
package lsz_pkg;

  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned MAX_HEIGHT  = 1024;
  localparam int unsigned SAMPLE_BITS = 16;

  localparam int unsigned ADDR_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT);
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned EDGE_W  = 8;
  localparam int unsigned MEM_W   = 2 * SAMPLE_BITS;
  localparam int unsigned REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(3);
  localparam logic [DIM_W-1:0] DIM_MAX_W = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] DIM_MAX_H = DIM_W'(MAX_HEIGHT);

  localparam logic [EDGE_W-1:0] EDGE_ON  = EDGE_W'(255);
  localparam logic [EDGE_W-1:0] EDGE_OFF = EDGE_W'(0);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // one word in flight between the fetch and the compare stage
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [ADDR_W-1:0]             addr;
    logic [POS_W-1:0]              row;
    logic [POS_W-1:0]              col;
    logic                          emit;
  } lsz_item_t;

  function automatic logic [DIM_W-1:0] lsz_clamp(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v < DIM_MIN) r = DIM_MIN;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [SAMPLE_BITS:0] lsz_mag(input logic [SAMPLE_BITS-1:0] v);
    logic [SAMPLE_BITS:0] ext;
    ext = {v[SAMPLE_BITS-1], v};
    return v[SAMPLE_BITS-1] ? (~ext + (SAMPLE_BITS+1)'(1)) : ext;
  endfunction

endpackage
`default_nettype wire

[src/level_set_zero_crossing_edge.sv]
// Top level of the level-set zero-crossing edge marker.
//
// Input channel: one signed Q8.8 phi word per handshake, raster order.
// Output channel: one word per interior pixel (row 1..h-2, col 1..w-2),
// carrying row, column and 255 on the zero contour or 0 otherwise.
// Border pixels produce no output word.
// Config port: cfg_index 0 sets width, 1 sets height (values clamp to 3..1024).
// The word for a pixel passes through a fetch stage, taken when the input that
// completes its window is accepted, and then through the output register.
// Throughput: one input word per cycle while the receiver is not stalling, set by
// the single line-store RAM doing one read and one write per cycle on different columns.
// Reset: position counters and window cleared, sizes 1024, no RAM sweep.
// A stalled receiver holds the output register; the fetch stage still takes
// one more word, and an input that produces no output keeps draining.
`timescale 1ns / 1ps
`default_nettype none
module level_set_zero_crossing_edge (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lsz_pkg::REG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [lsz_pkg::DIM_W-1:0]         cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [lsz_pkg::SAMPLE_BITS-1:0] phi_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [lsz_pkg::POS_W-1:0]              pixel_row_o,
  output logic [lsz_pkg::POS_W-1:0]              pixel_col_o,
  output logic [lsz_pkg::EDGE_W-1:0]             edge_value_o
);

  localparam int unsigned SB = lsz_pkg::SAMPLE_BITS;

  logic [lsz_pkg::DIM_W-1:0]  width_q, height_q, w_eff, h_eff;
  logic [lsz_pkg::ADDR_W-1:0] col_q, col_d;
  logic [lsz_pkg::ROW_W-1:0]  row_q, row_d;
  logic [lsz_pkg::DIM_W-1:0]  col_inc, row_inc;
  logic                       accept, move;
  logic                       s1_valid_q;
  lsz_pkg::lsz_item_t         s1_q, s1_d;
  logic [lsz_pkg::MEM_W-1:0]  rd_data;
  logic                       edge_hit;
  logic                       out_valid_q;
  logic [lsz_pkg::POS_W-1:0]  out_row_q, out_col_q;
  logic [lsz_pkg::EDGE_W-1:0] out_edge_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lsz_pkg::DIM_W'(lsz_pkg::MAX_WIDTH);
      height_q <= lsz_pkg::DIM_W'(lsz_pkg::MAX_HEIGHT);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lsz_pkg::REG_WIDTH:  width_q  <= cfg_wdata_i;
        lsz_pkg::REG_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign w_eff = lsz_pkg::lsz_clamp(width_q, lsz_pkg::DIM_MAX_W);
  assign h_eff = lsz_pkg::lsz_clamp(height_q, lsz_pkg::DIM_MAX_H);

  // handshake
  assign move       = s1_valid_q && (!s1_q.emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || move;
  assign accept     = in_valid_i && in_ready_o;

  // raster position
  assign col_inc = lsz_pkg::DIM_W'(col_q) + lsz_pkg::DIM_W'(1);
  assign row_inc = lsz_pkg::DIM_W'(row_q) + lsz_pkg::DIM_W'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= h_eff) ? '0 : row_inc[lsz_pkg::ROW_W-1:0];
    end else begin
      col_d = col_inc[lsz_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // fetch stage
  always_comb begin
    s1_d.sample = phi_value_i;
    s1_d.addr   = col_q;
    s1_d.row    = lsz_pkg::POS_W'(row_q - lsz_pkg::ROW_W'(1));
    s1_d.col    = lsz_pkg::POS_W'(col_q - lsz_pkg::ADDR_W'(1));
    s1_d.emit   = (row_q >= lsz_pkg::ROW_W'(2)) && (col_q >= lsz_pkg::ADDR_W'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  // the column written back is the one before the column being read, so the two never coincide
  lsz_line_mem u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (move),
    .wr_addr_i (s1_q.addr),
    .wr_data_i ({rd_data[SB-1:0], s1_q.sample})
  );

  lsz_edge_core u_edge_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_i   (move),
    .item_i    (s1_q),
    .rd_data_i (rd_data),
    .edge_o    (edge_hit)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move && s1_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move && s1_q.emit) begin
      out_row_q  <= s1_q.row;
      out_col_q  <= s1_q.col;
      out_edge_q <= edge_hit ? lsz_pkg::EDGE_ON : lsz_pkg::EDGE_OFF;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_row_o  = out_row_q;
  assign pixel_col_o  = out_col_q;
  assign edge_value_o = out_edge_q;

`ifndef SYNTH
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted word did not reach fetch stage");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(move) && $past(s1_q.emit)))
    else $error("output word without an interior pixel");

  a_edge_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (edge_value_o == lsz_pkg::EDGE_ON || edge_value_o == lsz_pkg::EDGE_OFF))
    else $error("bad edge code");

  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_row_o != '0 && pixel_col_o != '0))
    else $error("border pixel reported");
`endif

endmodule
`default_nettype wire

[src/lsz_line_mem.sv]
// Line store RAM: upper and middle row samples packed in one word, registered read.
`timescale 1ns / 1ps
`default_nettype none
module lsz_line_mem (
  input  wire logic                         clk_i,
  input  wire logic                         rd_en_i,
  input  wire logic [lsz_pkg::ADDR_W-1:0]   rd_addr_i,
  output logic      [lsz_pkg::MEM_W-1:0]    rd_data_o,
  input  wire logic                         wr_en_i,
  input  wire logic [lsz_pkg::ADDR_W-1:0]   wr_addr_i,
  input  wire logic [lsz_pkg::MEM_W-1:0]    wr_data_i
);

  logic [lsz_pkg::MEM_W-1:0] mem [lsz_pkg::MAX_WIDTH];
  logic [lsz_pkg::MEM_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

[src/lsz_edge_core.sv]
// 3x3 window shift register and zero-crossing classifier.
`timescale 1ns / 1ps
`default_nettype none
module lsz_edge_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       shift_i,
  input  wire lsz_pkg::lsz_item_t         item_i,
  input  wire logic [lsz_pkg::MEM_W-1:0]  rd_data_i,
  output logic                            edge_o
);

  localparam int unsigned SB = lsz_pkg::SAMPLE_BITS;

  lsz_pkg::sample_t win_q [6];
  lsz_pkg::sample_t top, mid, bot, ctr;
  lsz_pkg::sample_t nb [8];
  logic [SB:0]      ctr_mag;
  logic             ctr_pos;
  logic             hit;

  assign top = rd_data_i[lsz_pkg::MEM_W-1:SB];
  assign mid = rd_data_i[SB-1:0];
  assign bot = item_i.sample;
  assign ctr = win_q[4];

  assign nb[0] = win_q[0];
  assign nb[1] = win_q[3];
  assign nb[2] = top;
  assign nb[3] = win_q[1];
  assign nb[4] = mid;
  assign nb[5] = win_q[2];
  assign nb[6] = win_q[5];
  assign nb[7] = bot;

  assign ctr_mag = lsz_pkg::lsz_mag(ctr);
  assign ctr_pos = !ctr[SB-1] && (ctr != '0);

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (ctr == '0) begin
        if (nb[k] != '0) hit = 1'b1;
      end else if ((ctr_mag < lsz_pkg::lsz_mag(nb[k])) &&
                   (ctr_pos != (!nb[k][SB-1] && (nb[k] != '0)))) begin
        hit = 1'b1;
      end
    end
  end

  assign edge_o = hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else if (shift_i) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= bot;
    end
  end

endmodule
`default_nettype wire
